@@ sv/bcl_pkg.sv @@
`default_nettype none
package bcl_pkg;

  localparam int TAG_W    = 32;
  localparam int REFS_W   = 8;
  localparam int OUT_SW   = 5;
  localparam int ADDR_MAX = 8;

  localparam logic [REFS_W-1:0] REF_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNREF  = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_REL = 1'b1;

  // result word, packed to match m_tdata (slot in the low bits)
  typedef struct packed {
    logic [REFS_W-1:0] ref_count;
    status_t           status;
    logic              hit;
    logic [OUT_SW-1:0] slot;
  } res_t;

  // write port of the slot store
  typedef struct packed {
    logic                en;
    logic [ADDR_MAX-1:0] addr;
    logic [TAG_W-1:0]    tag;
    logic [REFS_W-1:0]   refs;
  } store_wr_t;

endpackage
`default_nettype wire

@@ sv/bcl_store.sv @@
`default_nettype none
module bcl_store #(
  parameter int SLOTS = 32,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [SW-1:0]            rd_addr,
  input  wire bcl_pkg::store_wr_t       wr,
  output logic [bcl_pkg::TAG_W-1:0]     rd_tag,
  output logic [bcl_pkg::REFS_W-1:0]    rd_refs
);
  import bcl_pkg::*;

  logic [TAG_W-1:0]  tag_mem  [SLOTS];
  logic [REFS_W-1:0] refs_mem [SLOTS];
  logic [SLOTS-1:0]  valid;
  logic [TAG_W-1:0]  tag_q;
  logic [REFS_W-1:0] refs_q;
  logic              vld_q;
  logic [SW-1:0]     wa;

  assign wa = wr.addr[SW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tag_mem[wa]  <= wr.tag;
      refs_mem[wa] <= wr.refs;
    end
    tag_q  <= tag_mem[rd_addr];
    refs_q <= refs_mem[rd_addr];
  end

  // entries never written read as zero tag, zero count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) valid[wa] <= 1'b1;
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_tag  = vld_q ? tag_q  : '0;
  assign rd_refs = vld_q ? refs_q : '0;

endmodule
`default_nettype wire

@@ sv/bcl_order.sv @@
`default_nettype none
module bcl_order #(
  parameter int SLOTS = 32,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [SW-1:0] rd_pos,
  output logic [SW-1:0]      rd_slot,
  input  wire logic          mtf_en,
  input  wire logic [SW-1:0] mtf_slot
);
  import bcl_pkg::*;

  logic [SW-1:0]    order [SLOTS];
  logic [SLOTS-1:0] eq;
  logic [SLOTS-1:0] ahead;

  assign rd_slot = order[rd_pos];

  // ahead[i]: the moved slot sits at a position below i, so i holds
  always_comb begin
    for (int i = 0; i < SLOTS; i++) eq[i] = (order[i] == mtf_slot);
    ahead[0] = 1'b0;
    for (int i = 1; i < SLOTS; i++) ahead[i] = ahead[i-1] | eq[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) order[i] <= SW'(SLOTS - 1 - i);
    end else if (mtf_en) begin
      order[0] <= mtf_slot;
      for (int i = 1; i < SLOTS; i++) begin
        if (!ahead[i]) order[i] <= order[i-1];
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/buffer_cache_lru_refcount.sv @@
// Buffer cache with recency order and per-slot reference counts.
// Input channel s_*: one request per accepted beat. s_tuser is the kind
// (0 get, 1 release); s_tdata carries the block tag and the slot to release.
// Output channel m_*: exactly one result per request (slot, hit, status,
// reference count after the request).
// A get walks the recency list from the most recent end, one slot per cycle
// through the single read port of the slot store, comparing tags; on a miss
// it walks again from the least recent end looking for a zero count.
// A release with an out-of-range slot index skips the store read; a count
// dropping to zero moves the slot to the front of the list.
// s_tready is high only while no request is in progress; the next request is
// taken while a finished result still waits in the output register.
// If the receiver stalls, the next result is held inside the block until the
// output register frees, and no new request is taken meanwhile.
// Reset: all tags and counts read as zero, list position i holds slot
// SLOTS-1-i. No clearing pass is needed; the block is ready after reset.
`default_nettype none
module buffer_cache_lru_refcount #(
  parameter int SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // block_number[31:0], slot_index[36:32], zero pad
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // slot[4:0], hit[5], status[7:6], ref_count[15:8]
);
  import bcl_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HSRCH = 3'd1;
  localparam logic [2:0] S_FSRCH = 3'd2;
  localparam logic [2:0] S_RCHK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [SW-1:0]     ip;
  logic              idone;
  logic              cv;
  logic [SW-1:0]     cslot;
  logic              clast;
  logic [TAG_W-1:0]  blk;
  logic [OUT_SW-1:0] ridx;
  res_t              res;
  res_t              out_res;

  logic [SW-1:0]     rd_addr;
  logic [SW-1:0]     ord_slot;
  logic [TAG_W-1:0]  rd_tag;
  logic [REFS_W-1:0] rd_refs;
  store_wr_t         wr;
  logic              mtf_en;
  logic [REFS_W-1:0] refs_dec;

  logic              in_acc;
  logic [OUT_SW-1:0] in_idx;
  logic              idx_ok;

  assign in_acc   = s_tvalid && s_tready;
  assign in_idx   = s_tdata[36:32];
  assign idx_ok   = (32'(in_idx) < SLOTS);
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_res;
  assign refs_dec = rd_refs - 8'd1;

  bcl_store #(.SLOTS(SLOTS)) u_store (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .wr(wr),
    .rd_tag(rd_tag), .rd_refs(rd_refs)
  );

  bcl_order #(.SLOTS(SLOTS)) u_order (
    .clk(clk), .rst(rst), .rd_pos(ip), .rd_slot(ord_slot),
    .mtf_en(mtf_en), .mtf_slot(SW'(ridx))
  );

  // store read address: release index on accept, walk slot otherwise
  always_comb begin
    rd_addr = ord_slot;
    if (state == S_IDLE) rd_addr = SW'(in_idx);
  end

  always_comb begin
    wr      = '0;
    mtf_en  = 1'b0;
    unique case (state)
      S_HSRCH: begin
        if (cv && rd_tag == blk && rd_refs != REF_MAX) begin
          wr.en   = 1'b1;
          wr.addr = ADDR_MAX'(cslot);
          wr.tag  = blk;
          wr.refs = rd_refs + 8'd1;
        end
      end
      S_FSRCH: begin
        if (cv && rd_refs == '0) begin
          wr.en   = 1'b1;
          wr.addr = ADDR_MAX'(cslot);
          wr.tag  = blk;
          wr.refs = 8'd1;
        end
      end
      S_RCHK: begin
        if (rd_refs != '0) begin
          wr.en   = 1'b1;
          wr.addr = ADDR_MAX'(ridx);
          wr.tag  = rd_tag;
          wr.refs = refs_dec;
          mtf_en  = (refs_dec == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cv       <= 1'b0;
      idone    <= 1'b0;
      ip       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cv <= 1'b0;
          if (in_acc) begin
            blk  <= s_tdata[31:0];
            ridx <= in_idx;
            if (s_tuser == KIND_GET) begin
              ip    <= '0;
              idone <= 1'b0;
              state <= S_HSRCH;
            end else if (idx_ok) begin
              state <= S_RCHK;
            end else begin
              res   <= '{ref_count: '0, status: ST_UNREF, hit: 1'b0, slot: in_idx};
              state <= S_DONE;
            end
          end
        end
        S_HSRCH: begin
          cv    <= !idone;
          cslot <= ord_slot;
          clast <= (ip == LAST);
          if (!idone) begin
            if (ip == LAST) idone <= 1'b1;
            else ip <= ip + 1'b1;
          end
          if (cv && rd_tag == blk) begin
            if (rd_refs == REF_MAX)
              res <= '{ref_count: REF_MAX, status: ST_SAT, hit: 1'b1,
                       slot: OUT_SW'(cslot)};
            else
              res <= '{ref_count: rd_refs + 8'd1, status: ST_OK, hit: 1'b1,
                       slot: OUT_SW'(cslot)};
            state <= S_DONE;
          end else if (cv && clast) begin
            ip    <= LAST;
            idone <= 1'b0;
            state <= S_FSRCH;
          end
        end
        S_FSRCH: begin
          cv    <= !idone;
          cslot <= ord_slot;
          clast <= (ip == '0);
          if (!idone) begin
            if (ip == '0) idone <= 1'b1;
            else ip <= ip - 1'b1;
          end
          if (cv && rd_refs == '0) begin
            res   <= '{ref_count: 8'd1, status: ST_OK, hit: 1'b0, slot: OUT_SW'(cslot)};
            state <= S_DONE;
          end else if (cv && clast) begin
            res   <= '{ref_count: '0, status: ST_NOFREE, hit: 1'b0, slot: '0};
            state <= S_DONE;
          end
        end
        S_RCHK: begin
          if (rd_refs == '0)
            res <= '{ref_count: '0, status: ST_UNREF, hit: 1'b0, slot: ridx};
          else
            res <= '{ref_count: refs_dec, status: ST_OK, hit: 1'b0, slot: ridx};
          state <= S_DONE;
        end
        S_DONE: begin
          cv <= 1'b0;
          if (!m_tvalid || m_tready) begin
            out_res  <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while previous one still in progress");

  a_nofree_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.status == ST_NOFREE) |-> (out_res.ref_count == '0 && !out_res.hit))
    else $error("no-free result carries a count or hit");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.hit) |-> (out_res.status == ST_OK || out_res.status == ST_SAT))
    else $error("hit reported with release status");

  a_mtf_release: assert property (@(posedge clk) disable iff (rst)
    mtf_en |-> (state == S_RCHK && wr.en && wr.refs == '0))
    else $error("move to front outside a release that drops count to zero");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> (state == S_DONE && !wr.en))
    else $error("store written without finishing the request");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import bcl_pkg::*;

  localparam int SLOTS          = 32;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int POOL_SIZE      = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // block_number[31:0], slot_index[36:32], zero pad
  logic        s_tuser  = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // slot[4:0], hit[5], status[7:6], ref_count[15:8]

  buffer_cache_lru_refcount #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // directed request: repeated reps times, block and slot advancing by their steps
  typedef struct packed {
    logic              kind;
    logic [TAG_W-1:0]  blk;
    logic [TAG_W-1:0]  blk_step;
    logic [4:0]        idx;
    logic [4:0]        idx_step;
    logic [8:0]        reps;
    logic              typed;
    res_t              want;
  } req_row_t;

  req_row_t plan[$];
  res_t     expected_results[$];

  // cache shadow
  logic [TAG_W-1:0]  tag_of   [SLOTS];
  logic [REFS_W-1:0] refs_of  [SLOTS];
  logic [4:0]        lru_list [SLOTS];  // position 0 = most recently freed

  int   mismatches = 0;
  int   burst_left = 0;
  int   hold_asked = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  int   idle_cycles = 0;
  int unsigned rx_cyc = 0;
  logic [1:0]  rx_mode = 2'd0;
  res_t seen_res, head_res;

  function automatic res_t result_of(input logic [4:0] slot, input logic hit,
                                     input status_t status, input logic [7:0] refs);
    res_t r;
    r.slot      = slot;
    r.hit       = hit;
    r.status    = status;
    r.ref_count = refs;
    return r;
  endfunction

  function automatic void plan_row(input logic kind, input logic [31:0] blk,
                                   input logic [31:0] blk_step, input logic [4:0] idx,
                                   input logic [4:0] idx_step, input logic [8:0] reps,
                                   input logic typed, input res_t want);
    req_row_t row;
    row.kind     = kind;
    row.blk      = blk;
    row.blk_step = blk_step;
    row.idx      = idx;
    row.idx_step = idx_step;
    row.reps     = reps;
    row.typed    = typed;
    row.want     = want;
    plan.push_back(row);
  endfunction

  // Updates the shadow and returns what the block must answer.
  task automatic cache_access(input logic kind, input logic [31:0] blk,
                              input logic [4:0] idx, output res_t r);
    int         pos;
    logic [4:0] s;
    bit         done;
    r    = '0;
    done = 1'b0;
    pos  = 0;
    if (kind == KIND_GET) begin
      for (int i = 0; i < SLOTS && !done; i++) begin
        s = lru_list[i];
        if (tag_of[s] == blk) begin
          done   = 1'b1;
          r.slot = s;
          r.hit  = 1'b1;
          if (refs_of[s] == REF_MAX) begin
            r.status = ST_SAT;
          end else begin
            refs_of[s] = refs_of[s] + 1'b1;
            r.status   = ST_OK;
          end
          r.ref_count = refs_of[s];
        end
      end
      // miss: oldest free slot
      for (int i = SLOTS - 1; i >= 0 && !done; i--) begin
        s = lru_list[i];
        if (refs_of[s] == '0) begin
          done        = 1'b1;
          tag_of[s]   = blk;
          refs_of[s]  = 8'd1;
          r.slot      = s;
          r.status    = ST_OK;
          r.ref_count = 8'd1;
        end
      end
      if (!done) r.status = ST_NOFREE;
    end else begin
      r.slot = idx;
      if (refs_of[idx] == '0) begin
        r.status = ST_UNREF;
      end else begin
        refs_of[idx] = refs_of[idx] - 1'b1;
        r.status     = ST_OK;
        r.ref_count  = refs_of[idx];
        if (refs_of[idx] == '0) begin
          for (int i = 0; i < SLOTS; i++)
            if (lru_list[i] == idx) pos = i;
          for (int i = pos; i > 0; i--)
            lru_list[i] = lru_list[i-1];
          lru_list[0] = idx;
        end
      end
    end
  endtask

  // Offers one request, waits for it to be taken, then maybe opens an idle gap.
  task automatic send_request(input logic kind, input logic [31:0] blk,
                              input logic [4:0] idx, input logic typed, input res_t want);
    res_t predicted;
    int   gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, idx, blk};
    do @(posedge clk); while (!s_tready);
    cache_access(kind, blk, idx, predicted);
    expected_results.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(80, 20) : $urandom_range(6, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(10);
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      if (rx_cyc[6:0] == 7'd0) rx_mode <= 2'($urandom_range(3));
      case (rx_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(1));
        2'd2:    m_tready <= ($urandom_range(3) != 0);
        default: m_tready <= ((rx_cyc % 7) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = res_t'(m_tdata);
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: slot %0d status %0d",
               seen_res.slot, seen_res.status);
        mismatches++;
      end else begin
        head_res = expected_results.pop_front();
        if (seen_res.slot != head_res.slot) begin
          $error("slot: expected %0d, actual %0d", head_res.slot, seen_res.slot);
          mismatches++;
        end
        if (seen_res.hit != head_res.hit) begin
          $error("hit: expected %0d, actual %0d", head_res.hit, seen_res.hit);
          mismatches++;
        end
        if (seen_res.status != head_res.status) begin
          $error("status: expected %0d, actual %0d", head_res.status, seen_res.status);
          mismatches++;
        end
        if (seen_res.ref_count != head_res.ref_count) begin
          $error("ref_count: expected %0d, actual %0d",
                 head_res.ref_count, seen_res.ref_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_row_t    row;
    logic        kind;
    logic [31:0] blk;
    logic [4:0]  idx;
    logic [4:0]  held [SLOTS];
    int          n_held;
    int          get_pct;
    logic [31:0] pool [POOL_SIZE];

    for (int i = 0; i < SLOTS; i++) begin
      tag_of[i]   = '0;
      refs_of[i]  = '0;
      lru_list[i] = 5'(SLOTS - 1 - i);
    end
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom();
    get_pct = 50;

    // tags start at zero, so block 0 hits the front slot
    plan_row(KIND_GET, 32'h0, 32'h0, 5'd0, 5'd0, 9'd1, 1'b1,
             result_of(5'd31, 1'b1, ST_OK, 8'd1));
    plan_row(KIND_REL, 32'hFFFF_FFFF, 32'h0, 5'd5, 5'd0, 9'd1, 1'b1,
             result_of(5'd5, 1'b0, ST_UNREF, 8'd0));
    plan_row(KIND_REL, 32'h0, 32'h0, 5'd31, 5'd0, 9'd1, 1'b1,
             result_of(5'd31, 1'b0, ST_OK, 8'd0));
    plan_row(KIND_GET, 32'hFFFF_FFFF, 32'h0, 5'd31, 5'd0, 9'd1, 1'b1,
             result_of(5'd0, 1'b0, ST_OK, 8'd1));
    plan_row(KIND_GET, 32'hFFFF_FFFF, 32'h0, 5'd0, 5'd0, 9'd1, 1'b0, '0);
    plan_row(KIND_REL, 32'h0, 32'h0, 5'd0, 5'd0, 9'd2, 1'b0, '0);
    plan_row(KIND_REL, 32'h0, 32'h0, 5'd0, 5'd0, 9'd1, 1'b1,
             result_of(5'd0, 1'b0, ST_UNREF, 8'd0));
    // drive one count to the top, then one more get saturates
    plan_row(KIND_GET, 32'h1234_5678, 32'h0, 5'd0, 5'd0, 9'd255, 1'b0, '0);
    plan_row(KIND_GET, 32'h1234_5678, 32'h0, 5'd0, 5'd0, 9'd1, 1'b1,
             result_of(5'd1, 1'b1, ST_SAT, 8'hFF));
    // occupy every remaining slot, then a miss finds nothing free
    plan_row(KIND_GET, 32'h8000_0000, 32'h1, 5'd0, 5'd0, 9'd31, 1'b0, '0);
    plan_row(KIND_GET, 32'hDEAD_BEEF, 32'h0, 5'd31, 5'd0, 9'd1, 1'b1,
             result_of(5'd0, 1'b0, ST_NOFREE, 8'd0));
    plan_row(KIND_REL, 32'h5A5A_A5A5, 32'h0, 5'd0, 5'd1, 9'd32, 1'b0, '0);
    plan_row(KIND_GET, 32'h0, 32'h0, 5'd0, 5'd0, 9'd1, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      row = plan[r];
      for (int k = 0; k < row.reps; k++)
        send_request(row.kind, row.blk + k * row.blk_step, row.idx + 5'(k * row.idx_step),
                     row.typed, row.want);
    end

    wait_all_results();
    hold_asked++;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // vary the share of gets, to fill or to drain the cache
      if (n % 100 == 0) get_pct = $urandom_range(80, 25);
      if (n == RANDOM_ITEMS / 2) hold_asked++;
      if (n % 500 == 499) wait_all_results();
      if ($urandom_range(99) < get_pct) begin
        kind = KIND_GET;
        blk  = ($urandom_range(4) == 0) ? $urandom() : pool[$urandom_range(POOL_SIZE - 1)];
        idx  = 5'($urandom());
      end else begin
        kind   = KIND_REL;
        blk    = $urandom();
        n_held = 0;
        for (int i = 0; i < SLOTS; i++)
          if (refs_of[i] != '0) begin
            held[n_held] = 5'(i);
            n_held++;
          end
        if (n_held != 0 && $urandom_range(9) != 0) idx = held[$urandom_range(n_held - 1)];
        else idx = 5'($urandom());
      end
      send_request(kind, blk, idx, 1'b0, '0);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
